// File: src/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// shared types, constants and coding helpers of the position delta encoder
// ----------------------------------------------------------------------------
package pde_pkg;

    localparam int unsigned OFFSET_W    = 31;
    localparam int unsigned POSITION_W  = 32;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAYLOAD_W   = 7;
    localparam int unsigned MORE_BIT    = 7;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    // which of the two values of an entry the back end is sending
    typedef enum logic
    {
        PH_OFFSET   = 1'b0,
        PH_POSITION = 1'b1
    } pde_phase_t;

    // one classified entry: both zig-zag values and their byte counts
    typedef struct packed
    {
        logic [VALUE_W-1:0] zz_off;
        logic [COUNT_W-1:0] n_off;
        logic [VALUE_W-1:0] zz_pos;
        logic [COUNT_W-1:0] n_pos;
    } pde_entry_t;

    function automatic logic [VALUE_W-1:0] zigzag(input logic [VALUE_W-1:0] v);
        zigzag = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    // number of 7-bit groups needed, one to five
    function automatic logic [COUNT_W-1:0] byte_count(input logic [VALUE_W-1:0] zz);
        priority if (zz[31:28] != 4'd0)
            byte_count = 3'd5;
        else if (zz[27:21] != 7'd0)
            byte_count = 3'd4;
        else if (zz[20:14] != 7'd0)
            byte_count = 3'd3;
        else if (zz[13:7] != 7'd0)
            byte_count = 3'd2;
        else
            byte_count = 3'd1;
    endfunction

    // 7-bit group number idx, least significant first
    function automatic logic [PAYLOAD_W-1:0] group_sel(input logic [VALUE_W-1:0] zz,
                                                       input logic [COUNT_W-1:0] idx);
        unique case (idx)
            3'd0:    group_sel = zz[6:0];
            3'd1:    group_sel = zz[13:7];
            3'd2:    group_sel = zz[20:14];
            3'd3:    group_sel = zz[27:21];
            default: group_sel = {3'b000, zz[31:28]};
        endcase
    endfunction

endpackage

// File: src/pde_ifs.sv
// ----------------------------------------------------------------------------
// pde channel interfaces
// entry input, byte output and omit register write channels
// ----------------------------------------------------------------------------
interface pde_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [pde_pkg::OFFSET_W-1:0]          insn_offset;
    logic signed [pde_pkg::POSITION_W-1:0] src_pos;
    logic                                  stmt_flag;
    logic                                  new_table;

    modport source (output valid, insn_offset, src_pos, stmt_flag, new_table,
                    input ready);
    modport sink (input valid, insn_offset, src_pos, stmt_flag, new_table,
                  output ready);
endinterface

interface pde_out_if;
    logic                         valid;
    logic                         ready;
    logic [pde_pkg::BYTE_W-1:0]   out_byte;
    logic                         last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink (input valid, out_byte, last_byte, output ready);
endinterface

interface pde_cfg_if;
    logic valid;
    logic ready;
    logic omit_positions;

    modport source (output valid, omit_positions, input ready);
    modport sink (input valid, omit_positions, output ready);
endinterface

// File: src/pde_front.sv
// ----------------------------------------------------------------------------
// pde_front
// accepts entries, forms deltas and zig-zag values, sizes them, fills queue
// ----------------------------------------------------------------------------
module pde_front
(
    input  logic                clk,
    input  logic                rst_n,
    pde_in_if.sink              in_ch,
    pde_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                push,
    output pde_pkg::pde_entry_t push_entry
);
    import pde_pkg::*;

    logic                  omit_reg;
    logic                  omit_next;
    logic [OFFSET_W-1:0]   prev_offset_reg;
    logic [OFFSET_W-1:0]   prev_offset_next;
    logic [POSITION_W-1:0] prev_position_reg;
    logic [POSITION_W-1:0] prev_position_next;
    logic                  accept;
    logic [OFFSET_W-1:0]   base_off;
    logic [POSITION_W-1:0] base_pos;
    logic [VALUE_W-1:0]    d_off;
    logic [VALUE_W-1:0]    d_pos;
    logic [VALUE_W-1:0]    folded_off;

    assign cfg.ready   = 1'b1;
    // omitted entries never need queue room
    assign in_ch.ready = omit_reg | ~q_full;
    assign accept      = in_ch.valid & in_ch.ready;
    assign push        = accept & ~omit_reg;

    assign base_off   = in_ch.new_table ? '0 : prev_offset_reg;
    assign base_pos   = in_ch.new_table ? '0 : prev_position_reg;
    assign d_off      = {1'b0, in_ch.insn_offset} - {1'b0, base_off};
    assign d_pos      = VALUE_W'(in_ch.src_pos) - base_pos;
    // expression entries carry the inverted offset delta
    assign folded_off = in_ch.stmt_flag ? d_off : ~d_off;

    always_comb
    begin
        push_entry.zz_off = zigzag(folded_off);
        push_entry.zz_pos = zigzag(d_pos);
        push_entry.n_off  = byte_count(push_entry.zz_off);
        push_entry.n_pos  = byte_count(push_entry.zz_pos);
    end

    always_comb
    begin
        omit_next          = omit_reg;
        prev_offset_next   = prev_offset_reg;
        prev_position_next = prev_position_reg;
        if (cfg.valid)
            omit_next = cfg.omit_positions;
        if (push)
        begin
            prev_offset_next   = in_ch.insn_offset;
            prev_position_next = VALUE_W'(in_ch.src_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omit_reg          <= 1'b0;
            prev_offset_reg   <= '0;
            prev_position_reg <= '0;
        end
        else
        begin
            omit_reg          <= omit_next;
            prev_offset_reg   <= prev_offset_next;
            prev_position_reg <= prev_position_next;
        end
    end

endmodule

// File: src/pde_queue.sv
// ----------------------------------------------------------------------------
// pde_queue
// short entry queue between front and back end
// ----------------------------------------------------------------------------
module pde_queue
#(
    parameter int unsigned DEPTH = pde_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pde_pkg::pde_entry_t push_entry,
    input  logic                pop,
    output pde_pkg::pde_entry_t head,
    output logic                full,
    output logic                empty
);
    import pde_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pde_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// File: src/pde_back.sv
// ----------------------------------------------------------------------------
// pde_back
// walks the queue head into the output register, one 7-bit group per cycle while the output can advance
// ----------------------------------------------------------------------------
module pde_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  pde_pkg::pde_entry_t head,
    input  logic                q_empty,
    output logic                pop,
    pde_out_if.source           out_ch
);
    import pde_pkg::*;

    pde_phase_t          phase_reg;
    pde_phase_t          phase_next;
    logic [COUNT_W-1:0]  idx_reg;
    logic [COUNT_W-1:0]  idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic                out_adv;
    logic                emit;
    logic [VALUE_W-1:0]  cur_zz;
    logic [COUNT_W-1:0]  cur_n;
    logic                cur_more;
    logic [BYTE_W-1:0]   byte_val;
    logic                byte_last;

    assign out_adv  = ~out_valid_reg | out_ch.ready;
    assign emit     = out_adv & ~q_empty;
    assign cur_zz   = (phase_reg == PH_OFFSET) ? head.zz_off : head.zz_pos;
    assign cur_n    = (phase_reg == PH_OFFSET) ? head.n_off : head.n_pos;
    assign cur_more = (idx_reg + 1'b1) != cur_n;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (emit)
        begin
            if (cur_more)
                idx_next = idx_reg + 1'b1;
            else
            begin
                idx_next = '0;
                unique case (phase_reg)
                    PH_OFFSET:   phase_next = PH_POSITION;
                    PH_POSITION: phase_next = PH_OFFSET;
                    default:     phase_next = PH_OFFSET;
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        byte_val  = {cur_more, group_sel(cur_zz, idx_reg)};
        byte_last = ~cur_more & (phase_reg == PH_POSITION);
        pop       = emit & byte_last;
    end

    assign out_valid_next = out_adv ? ~q_empty : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OFFSET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= byte_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.last_byte = out_last_reg;

`ifndef SYNTHESIS
    a_last_no_more: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !out_byte_reg[MORE_BIT])
        else $error("final byte carries more flag");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> idx_reg < cur_n)
        else $error("group index beyond value length");
    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0) && (phase_reg == PH_OFFSET))
        else $error("back end not rewound after entry");
    a_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_last_reg)
        else $error("entry retired without final byte");
`endif

endmodule

// File: src/position_delta_varint_encoder.sv
// ----------------------------------------------------------------------------
// position_delta_varint_encoder
// position table entries to delta, zig-zag, 7-bit varint byte stream
// ----------------------------------------------------------------------------
// each entry transfer (code offset, source position, statement flag, new
// table flag) is turned into two zig-zag values: the offset delta, inverted
// for expression entries, then the position delta, both wrapping at 32 bits
// against the previous encoded entry (or zero when new_table is set). each
// value leaves as one to five bytes, least significant group first, bit 7
// set when another byte of that value follows; last_byte marks the final
// byte of the entry, so an entry gives two to ten byte transfers. the back
// end sends one byte per cycle from its output register while the receiver
// is ready; the front end takes a new entry every cycle while the two-entry
// queue has room, so bursts of short entries flow back to back. with
// omit_positions set every entry is accepted each cycle and dropped: no
// bytes, no state change. the user must write omit_positions through the
// cfg channel only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module position_delta_varint_encoder
#(
    parameter int unsigned QUEUE_DEPTH = pde_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    pde_in_if.sink     in_ch,
    pde_out_if.source  out_ch,
    pde_cfg_if.sink    cfg
);
    import pde_pkg::*;

    // front to queue
    logic       push;
    pde_entry_t push_entry;
    // queue to back
    pde_entry_t head;
    logic       q_full;
    logic       q_empty;
    logic       pop;

    // classification: deltas, folding, zig-zag, byte counts, omit register
    pde_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples entry acceptance from byte output
    pde_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // byte serialiser with registered output
    pde_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

// File: tb/sv/position_delta_varint_encoder_tb.sv
// ----------------------------------------------------------------------------
// position_delta_varint_encoder_tb
// self-checking bench for the position delta varint encoder: a directed
// table of entries (extremes, expression and statement entries, new tables,
// descending offsets, omit on and off) followed by random table walks in
// phases with the omit register toggled. a local delta/zig-zag/varint
// predictor builds the awaited byte stream, which every output transfer is
// checked against, byte and last flag separately
// ----------------------------------------------------------------------------
module position_delta_varint_encoder_tb;

    import pde_pkg::*;

    localparam int unsigned MAX_WAIT       = 6;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // one position entry as offered on the input channel
    typedef struct packed
    {
        logic [OFFSET_W-1:0]          insn_offset;
        logic signed [POSITION_W-1:0] src_pos;
        logic                         stmt_flag;
        logic                         new_table;
    } entry_t;

    // one encoded byte as it should leave the block
    typedef struct packed
    {
        logic [BYTE_W-1:0] value;
        logic              is_last;
    } enc_byte_t;

    typedef enum logic [1:0]
    {
        ROW_ENTRY,
        ROW_OMIT_ON,
        ROW_OMIT_OFF
    } row_kind_t;

    // directed row; want_n of zero leaves the bytes to the predictor,
    // otherwise byte k of the entry is want[8k +: 8]
    typedef struct packed
    {
        row_kind_t           kind;
        logic [OFFSET_W-1:0] insn_offset;
        logic [31:0]         src_pos;
        logic                stmt_flag;
        logic                new_table;
        logic [3:0]          want_n;
        logic [79:0]         want;
    } row_t;

    localparam int unsigned N_ROWS = 21;

    localparam row_t DIRECTED [N_ROWS] = '{
        // straight after reset, zero deltas
        '{ROW_ENTRY,    31'h0,        32'h0,        1'b1, 1'b0, 4'd2,  80'h0000},
        // expression entry: zero delta inverts to minus one
        '{ROW_ENTRY,    31'h0,        32'h0,        1'b0, 1'b0, 4'd2,  80'h0001},
        // largest deltas, ten bytes
        '{ROW_ENTRY,    31'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 4'd10,
          80'h0FFFFFFFFE0FFFFFFFFE},
        // most negative position
        '{ROW_ENTRY,    31'h0,        32'h80000000, 1'b1, 1'b1, 4'd6,  80'h0FFFFFFFFF00},
        '{ROW_ENTRY,    31'h0,        32'hFFFFFFFF, 1'b1, 1'b1, 4'd2,  80'h0100},
        // one and two byte boundaries of the zig-zag value
        '{ROW_ENTRY,    31'h1,        32'h40,       1'b1, 1'b1, 4'd3,  80'h018002},
        '{ROW_ENTRY,    31'h1,        32'h3F,       1'b0, 1'b1, 4'd2,  80'h7E03},
        '{ROW_ENTRY,    31'h1,        32'hFFFFFFC0, 1'b1, 1'b1, 4'd2,  80'h7F02},
        '{ROW_ENTRY,    31'h100,      32'h10,       1'b1, 1'b0, 4'd0,  80'h0},
        // descending offsets
        '{ROW_ENTRY,    31'h10,       32'h5,        1'b1, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h0,        32'h7FFFFFFF, 1'b0, 1'b0, 4'd0,  80'h0},
        // wrapping deltas
        '{ROW_ENTRY,    31'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h0,        32'h7FFFFFFF, 1'b1, 1'b0, 4'd0,  80'h0},
        // omit, also together with a new table: nothing out, state kept
        '{ROW_OMIT_ON,  31'h0,        32'h0,        1'b0, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h1234,     32'h55,       1'b1, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h7FFFFFFF, 32'h80000000, 1'b0, 1'b1, 4'd0,  80'h0},
        '{ROW_OMIT_OFF, 31'h0,        32'h0,        1'b0, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h40,       32'h40,       1'b1, 1'b0, 4'd0,  80'h0},
        // alternating bit patterns
        '{ROW_ENTRY,    31'h55555555, 32'hAAAAAAAA, 1'b0, 1'b1, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h2AAAAAAA, 32'h55555555, 1'b1, 1'b0, 4'd0,  80'h0},
        '{ROW_ENTRY,    31'h7FFFFFFF, 32'h0,        1'b1, 1'b0, 4'd0,  80'h0}
    };

    logic clk;
    logic rst_n;

    pde_in_if  in_ch();
    pde_out_if out_ch();
    pde_cfg_if cfg_ch();

    position_delta_varint_encoder dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // predictor state: previous encoded entry and the omit register
    logic [OFFSET_W-1:0]   last_offset;
    logic [POSITION_W-1:0] last_position;
    logic                  omit_shadow;

    // bytes still to come from the block, oldest first
    enc_byte_t awaited_bytes[$];

    // random table walk, kept apart from the predictor state
    logic [OFFSET_W-1:0]   stim_offset;
    logic [POSITION_W-1:0] stim_position;

    logic        calm;      // no gaps on either side
    logic        hold_req;  // ask for the long receiver hold-off
    logic        rx_hold;   // receiver held off
    int unsigned mismatches;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    // zig-zag one 32-bit value and queue its 7-bit groups, low group first
    function automatic void queue_varint(input logic [VALUE_W-1:0] v,
                                         input logic closes_entry,
                                         input logic keep);
        logic [VALUE_W-1:0] zz;
        logic               more;
        enc_byte_t          b;
        zz = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
        do
        begin
            more = (zz >> PAYLOAD_W) != '0;
            b.value = {more, zz[PAYLOAD_W-1:0]};
            b.is_last = !more && closes_entry;
            if (keep)
                awaited_bytes.insert(awaited_bytes.size(), b);
            zz = zz >> PAYLOAD_W;
        end
        while (more);
    endfunction

    // deltas against the previous entry, statement flag folded into the
    // offset delta; keep low only advances the state
    function automatic void encode_entry(input entry_t e, input logic keep);
        logic [VALUE_W-1:0] off_delta;
        logic [VALUE_W-1:0] pos_delta;
        if (omit_shadow)
            return;
        off_delta = {1'b0, e.insn_offset}
                    - (e.new_table ? {VALUE_W{1'b0}} : {1'b0, last_offset});
        pos_delta = e.src_pos
                    - (e.new_table ? {VALUE_W{1'b0}} : last_position);
        if (!e.stmt_flag)
            off_delta = ~off_delta;
        queue_varint(off_delta, 1'b0, keep);
        queue_varint(pos_delta, 1'b1, keep);
        last_offset = e.insn_offset;
        last_position = e.src_pos;
    endfunction

    // mostly a plausible table walk, with jumps, descents and extremes mixed in
    function automatic entry_t random_entry();
        entry_t             e;
        int unsigned        pick;
        logic [VALUE_W-1:0] off_step;
        logic [VALUE_W-1:0] pos_step;
        logic [VALUE_W-1:0] raw;
        pick = $urandom_range(0, 99);
        off_step = $urandom >> $urandom_range(4, 31);
        pos_step = $urandom >> $urandom_range(0, 31);
        if (pick < 80)
        begin
            // ascending walk, a share of descents
            if (pick < 70)
                stim_offset = stim_offset + off_step[OFFSET_W-1:0];
            else
                stim_offset = stim_offset - off_step[OFFSET_W-1:0];
            if ($urandom_range(0, 1) == 1)
                stim_position = stim_position + pos_step;
            else
                stim_position = stim_position - pos_step;
        end
        else if (pick < 95)
        begin
            raw = $urandom;
            stim_offset = raw[OFFSET_W-1:0];
            stim_position = $urandom;
        end
        else
        begin
            stim_offset = ($urandom_range(0, 1) == 1) ? '1 : '0;
            case ($urandom_range(0, 3))
                0:       stim_position = 32'h0;
                1:       stim_position = 32'h7FFFFFFF;
                2:       stim_position = 32'h80000000;
                default: stim_position = 32'hFFFFFFFF;
            endcase
        end
        e.insn_offset = stim_offset;
        e.src_pos = stim_position;
        e.stmt_flag = ($urandom_range(0, 1) == 1);
        e.new_table = ($urandom_range(0, 9) == 0);
        return e;
    endfunction

    // offer one entry and return at the edge of its transfer, valid left high
    task automatic send_entry(input entry_t e);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.insn_offset <= e.insn_offset;
        in_ch.src_pos     <= e.src_pos;
        in_ch.stmt_flag   <= e.stmt_flag;
        in_ch.new_table   <= e.new_table;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // all awaited bytes out, then a settling wait for dropped entries to clear
    task automatic await_quiet();
        @(negedge clk);
        while (awaited_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write only with the block idle
    task automatic set_omit(input logic v);
        in_ch.valid <= 1'b0;
        await_quiet();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.omit_positions <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        omit_shadow = v;
    endtask

    task automatic run_random(input logic omit, input int unsigned n_items,
                              input logic no_gaps, input logic squeeze);
        entry_t e;
        set_omit(omit);
        calm = no_gaps;
        if (squeeze)
            hold_req <= 1'b1;
        repeat (n_items)
        begin
            e = random_entry();
            send_entry(e);
            encode_entry(e, 1'b1);
        end
    endtask

    // stimulus: directed table, then random phases
    initial
    begin
        row_t      row;
        entry_t    e;
        enc_byte_t b;

        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.insn_offset     = '0;
        in_ch.src_pos         = '0;
        in_ch.stmt_flag       = 1'b0;
        in_ch.new_table       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.omit_positions = 1'b0;
        last_offset           = '0;
        last_position         = '0;
        omit_shadow           = 1'b0;
        stim_offset           = '0;
        stim_position         = '0;
        calm                  = 1'b0;
        mismatches            = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_OMIT_ON:  set_omit(1'b1);
                ROW_OMIT_OFF: set_omit(1'b0);
                default:
                begin
                    e.insn_offset = row.insn_offset;
                    e.src_pos = row.src_pos;
                    e.stmt_flag = row.stmt_flag;
                    e.new_table = row.new_table;
                    send_entry(e);
                    // typed rows are checked as written, the state still advances
                    encode_entry(e, row.want_n == 0);
                    for (int k = 0; k < row.want_n; k++)
                    begin
                        b.value = row.want[8*k +: 8];
                        b.is_last = (k == row.want_n - 1);
                        awaited_bytes.insert(awaited_bytes.size(), b);
                    end
                end
            endcase
        end

        // phases: plain, omitted, with the long hold-off, omitted calm, calm
        run_random(1'b0, 120, 1'b0, 1'b0);
        run_random(1'b1, 20, 1'b0, 1'b0);
        run_random(1'b0, 120, 1'b0, 1'b1);
        run_random(1'b1, 15, 1'b1, 1'b0);
        run_random(1'b0, 120, 1'b1, 1'b0);

        in_ch.valid <= 1'b0;
        await_quiet();
        if (mismatches == 0)
            $display("[position_delta_varint_encoder] OK");
        else
            $display("[position_delta_varint_encoder] ERROR");
        $finish;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        hold_req = 1'b0;
        rx_hold  = 1'b0;
        wait (hold_req === 1'b1);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // byte receiver: random stall per transfer, checks against the awaited queue
    initial
    begin
        enc_byte_t   want;
        int unsigned stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_bytes.size() == 0)
                    report_mismatch($sformatf("byte %02h last %0b with nothing awaited",
                                              out_ch.out_byte, out_ch.last_byte));
                else
                begin
                    want = awaited_bytes.pop_front();
                    if (out_ch.out_byte !== want.value)
                        report_mismatch($sformatf("out_byte expected %02h actual %02h",
                                                  want.value, out_ch.out_byte));
                    if (out_ch.last_byte !== want.is_last)
                        report_mismatch($sformatf("last_byte expected %0b actual %0b",
                                                  want.is_last, out_ch.last_byte));
                end
                stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (stall_left != 0)
                stall_left--;
            out_ch.ready <= (stall_left == 0) && !rx_hold;
        end
    end

    // watchdog: too long without any transfer on any channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[position_delta_varint_encoder] ERROR");
        $finish;
    end

endmodule
